FILE: rtl/fblr_pkg.sv
// Shared types, constants and helpers for the framebuffer line/rectangle rasterizer.
// No dependencies; the top level, the step unit and the testbench import this package.
package fblr_pkg;

  // Default framebuffer geometry handed to the top-level parameters.
  localparam int FB_WIDTH_DEF  = 128;
  localparam int FB_HEIGHT_DEF = 128;

  // Working width of a coordinate: a 12-bit field plus room for x + width.
  localparam int CW = 13;
  // Width of the Bresenham error term; it stays within 1.5 times the larger delta.
  localparam int EW = 15;
  // Width of row * FB_WIDTH + column for the largest supported framebuffer.
  localparam int ADDR_FULL_W = 23;

  // Stream widths: the input fields packed, padded to whole bytes.
  localparam int S_TDATA_W = 88;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 16;
  localparam int PIX_W     = 16;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [EW-1:0] err_t;

  typedef enum logic [1:0] {
    OP_LINE = 2'd0,
    OP_RECT = 2'd1,
    OP_READ = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  // Walk state handed from the sequencer to the step unit.
  typedef struct packed {
    logic   is_rect;
    coord_t x;
    coord_t y;
    err_t   err;
    coord_t x_end;
    coord_t y_end;
    coord_t row_start;
    coord_t dx;
    coord_t dy;
    logic   x_neg;
    logic   y_neg;
  } walk_in_t;

  // Next walk state and what to do with the current pixel.
  typedef struct packed {
    coord_t x;
    coord_t y;
    err_t   err;
    logic   wr_en;
    logic   last;
  } walk_out_t;

  function automatic logic in_frame(coord_t x, coord_t y, coord_t w, coord_t h);
    return (x >= 0) && (x < w) && (y >= 0) && (y < h);
  endfunction

endpackage

FILE: rtl/framebuffer_line_rect_raster.sv
// Top level of the framebuffer rasterizer: sequencer, pixel memory and output register.
// Depends on fblr_pkg, fblr_ram and fblr_stepper.
//
// Usage:
//   One command is a transfer on the s_axis channel; tuser carries the opcode
//   (draw line, fill rectangle, read pixel, no-op). Every command produces
//   exactly one transfer on m_axis: the stored color and a valid flag for a
//   read inside the frame, zeros otherwise.
//   Commands run one at a time; s_axis_tready is high only while the sequencer
//   is idle. The shared step unit handles one pixel per cycle; a line walks
//   max(|dx|, |dy|) + 1 pixels and a rectangle its clipped width * height
//   pixels, around setup and result handling. A read goes from accept to the
//   result register through setup, memory read and finish.
//   After the result register loads, the sequencer is idle for the next command.
//   At reset the pixel memory is swept to zero, one word per cycle; the block
//   stays not ready while it clears FB_WIDTH * FB_HEIGHT words (16384 by default).
//   The result sits in an output register: while the receiver stalls, the
//   block still takes and executes the next command and only holds in the
//   finish step if a second result is ready before the first one is taken.
module framebuffer_line_rect_raster #(
  parameter int FB_WIDTH  = fblr_pkg::FB_WIDTH_DEF,
  parameter int FB_HEIGHT = fblr_pkg::FB_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // start_x[11:0], start_y[23:12], end_x[35:24], end_y[47:36],
  // rect_width[58:48], rect_height[69:59], color[85:70], zero pad[87:86]
  input  logic [fblr_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // opcode[1:0]
  input  logic [fblr_pkg::S_TUSER_W-1:0] s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // read_color[15:0]
  output logic [fblr_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // read_valid[0]
  output logic                           m_axis_tuser
);

  import fblr_pkg::*;

  localparam int DEPTH = FB_WIDTH * FB_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_SETUP  = 7'b0000100,
    ST_PREP   = 7'b0001000,
    ST_WALK   = 7'b0010000,
    ST_READ   = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_t;

  state_t state;

  // Captured command
  op_t               in_op;
  logic signed [11:0] in_sx;
  logic signed [11:0] in_sy;
  logic signed [11:0] in_ex;
  logic signed [11:0] in_ey;
  logic [10:0]       in_w;
  logic [10:0]       in_h;
  logic [PIX_W-1:0]  in_color;

  // Walk registers
  logic   is_rect;
  coord_t cur_x;
  coord_t cur_y;
  err_t   err;
  coord_t x_end;
  coord_t y_end;
  coord_t row_start;
  coord_t dx;
  coord_t dy;
  logic   x_neg;
  logic   y_neg;

  // Memory write stage and clear sweep
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [PIX_W-1:0] wr_data;
  logic [AW-1:0]    clr_addr;
  logic [PIX_W-1:0] rd_data;

  // Pending result
  logic [PIX_W-1:0] res_color;
  logic             res_valid;

  // Setup arithmetic on the captured command
  coord_t sx13;
  coord_t sy13;
  coord_t ex13;
  coord_t ey13;
  coord_t diff_x;
  coord_t diff_y;
  coord_t x_sum;
  coord_t y_sum;
  coord_t rect_x_last;
  coord_t rect_y_last;
  coord_t rect_x_first;
  coord_t rect_y_first;

  // Pixel address: one multiplier shared by reads and writes
  coord_t                 pix_x;
  coord_t                 pix_y;
  logic [ADDR_FULL_W-1:0] pix_prod;
  logic [AW-1:0]          pix_addr;

  walk_in_t  win;
  walk_out_t wout;

  assign sx13   = {in_sx[11], in_sx};
  assign sy13   = {in_sy[11], in_sy};
  assign ex13   = {in_ex[11], in_ex};
  assign ey13   = {in_ey[11], in_ey};
  assign diff_x = ex13 - sx13;
  assign diff_y = ey13 - sy13;

  // Clip the rectangle to the frame; an empty span ends with last < first.
  assign x_sum        = sx13 + coord_t'({2'b00, in_w});
  assign y_sum        = sy13 + coord_t'({2'b00, in_h});
  assign rect_x_last  = (x_sum > coord_t'(FB_WIDTH))  ? coord_t'(FB_WIDTH - 1)  :
                                                        x_sum - coord_t'(1);
  assign rect_y_last  = (y_sum > coord_t'(FB_HEIGHT)) ? coord_t'(FB_HEIGHT - 1) :
                                                        y_sum - coord_t'(1);
  assign rect_x_first = (sx13 < 0) ? coord_t'(0) : sx13;
  assign rect_y_first = (sy13 < 0) ? coord_t'(0) : sy13;

  assign pix_x    = (state == ST_SETUP) ? sx13 : cur_x;
  assign pix_y    = (state == ST_SETUP) ? sy13 : cur_y;
  assign pix_prod = ADDR_FULL_W'(pix_y[10:0]) * ADDR_FULL_W'(FB_WIDTH) +
                    ADDR_FULL_W'(pix_x[10:0]);
  assign pix_addr = pix_prod[AW-1:0];

  assign win = '{
    is_rect:   is_rect,
    x:         cur_x,
    y:         cur_y,
    err:       err,
    x_end:     x_end,
    y_end:     y_end,
    row_start: row_start,
    dx:        dx,
    dy:        dy,
    x_neg:     x_neg,
    y_neg:     y_neg
  };

  fblr_stepper #(
    .FB_WIDTH  (FB_WIDTH),
    .FB_HEIGHT (FB_HEIGHT)
  ) u_stepper (
    .win  (win),
    .wout (wout)
  );

  fblr_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (pix_addr),
    .rdata (rd_data)
  );

  assign s_axis_tready = (state == ST_IDLE);

  // Control: sequencer state and clear sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          case (in_op)
            OP_LINE, OP_RECT: state <= ST_PREP;
            OP_READ:          state <= ST_READ;
            default:          state <= ST_FINISH;
          endcase
        end
        ST_PREP: begin
          // Skip a rectangle that clipping left empty.
          if (is_rect && ((cur_x > x_end) || (cur_y > y_end))) begin
            state <= ST_FINISH;
          end else begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (wout.last) begin
            state <= ST_FINISH;
          end
        end
        ST_READ: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          // Hold until the output register is free or being taken.
          if (!m_axis_tvalid || m_axis_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Write strobe: every word of the clear sweep, in-frame pixels of a walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_en <= 1'b0;
    end else begin
      wr_en <= (state == ST_CLEAR) || ((state == ST_WALK) && wout.wr_en);
    end
  end

  // Output valid: load from the finish step, drop once the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == ST_FINISH) && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_CLEAR: begin
        wr_addr <= clr_addr;
        wr_data <= '0;
      end
      ST_IDLE: begin
        in_op    <= op_t'(s_axis_tuser);
        in_sx    <= s_axis_tdata[11:0];
        in_sy    <= s_axis_tdata[23:12];
        in_ex    <= s_axis_tdata[35:24];
        in_ey    <= s_axis_tdata[47:36];
        in_w     <= s_axis_tdata[58:48];
        in_h     <= s_axis_tdata[69:59];
        in_color <= s_axis_tdata[85:70];
      end
      ST_SETUP: begin
        res_color <= '0;
        res_valid <= (in_op == OP_READ) &&
                     in_frame(sx13, sy13, coord_t'(FB_WIDTH), coord_t'(FB_HEIGHT));
        if (in_op == OP_RECT) begin
          is_rect   <= 1'b1;
          cur_x     <= rect_x_first;
          cur_y     <= rect_y_first;
          row_start <= rect_x_first;
          x_end     <= rect_x_last;
          y_end     <= rect_y_last;
        end else begin
          is_rect <= 1'b0;
          cur_x   <= sx13;
          cur_y   <= sy13;
          x_end   <= ex13;
          y_end   <= ey13;
        end
        dx    <= diff_x[CW-1] ? -diff_x : diff_x;
        dy    <= diff_y[CW-1] ? -diff_y : diff_y;
        x_neg <= !(sx13 < ex13);
        y_neg <= !(sy13 < ey13);
      end
      ST_PREP: begin
        err <= EW'(dx) - EW'(dy);
      end
      ST_WALK: begin
        cur_x   <= wout.x;
        cur_y   <= wout.y;
        err     <= wout.err;
        wr_addr <= pix_addr;
        wr_data <= in_color;
      end
      ST_READ: begin
        // Read data is only meaningful for an address inside the frame.
        res_color <= res_valid ? rd_data : '0;
      end
      ST_FINISH: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          m_axis_tdata <= res_color;
          m_axis_tuser <= res_valid;
        end
      end
      default: begin
        res_valid <= 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/fblr_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module fblr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/fblr_stepper.sv
// Shared step unit: one Bresenham step or one raster-scan step per cycle.
// Depends on fblr_pkg for the walk structs and the clipping helper.
module fblr_stepper #(
  parameter int FB_WIDTH  = fblr_pkg::FB_WIDTH_DEF,
  parameter int FB_HEIGHT = fblr_pkg::FB_HEIGHT_DEF
) (
  input  fblr_pkg::walk_in_t  win,
  output fblr_pkg::walk_out_t wout
);

  import fblr_pkg::*;

  logic signed [EW:0] e2;
  logic signed [EW:0] dx_e;
  logic signed [EW:0] dy_e;
  logic               step_x;
  logic               step_y;
  err_t               dx_sel;
  err_t               dy_sel;
  coord_t             x_delta;
  coord_t             y_delta;
  logic               row_end;

  assign e2      = {win.err, 1'b0};
  assign dx_e    = (EW+1)'(win.dx);
  assign dy_e    = (EW+1)'(win.dy);
  assign step_x  = e2 > -dy_e;
  assign step_y  = e2 < dx_e;
  assign dx_sel  = step_y ? EW'(win.dx) : err_t'(0);
  assign dy_sel  = step_x ? EW'(win.dy) : err_t'(0);
  assign x_delta = win.x_neg ? {CW{1'b1}} : coord_t'(1);
  assign y_delta = win.y_neg ? {CW{1'b1}} : coord_t'(1);
  assign row_end = win.x == win.x_end;

  always_comb begin
    if (win.is_rect) begin
      // Rectangle bounds are pre-clipped, so every pixel lands in the frame.
      wout.wr_en = 1'b1;
      wout.last  = row_end && (win.y == win.y_end);
      wout.x     = row_end ? win.row_start : win.x + coord_t'(1);
      wout.y     = row_end ? win.y + coord_t'(1) : win.y;
      wout.err   = win.err;
    end else begin
      wout.wr_en = in_frame(win.x, win.y, coord_t'(FB_WIDTH), coord_t'(FB_HEIGHT));
      wout.last  = row_end && (win.y == win.y_end);
      wout.x     = step_x ? win.x + x_delta : win.x;
      wout.y     = step_y ? win.y + y_delta : win.y;
      wout.err   = win.err - dy_sel + dx_sel;
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for framebuffer_line_rect_raster: line, rectangle, read and no-op
// commands over the stream channels, checked against a pixel-exact framebuffer mirror.
// Depends on fblr_pkg and the RTL of the rasterizer only.
module tb;
  import fblr_pkg::*;

  localparam int FB_W       = FB_WIDTH_DEF;
  localparam int FB_H       = FB_HEIGHT_DEF;
  localparam int RAND_CMDS  = 1025;
  localparam int QUIET_CMDS = 100;       // tail of the run with no idling on either side
  localparam int DRAIN_CYC  = 64;
  localparam int CYCLE_CAP  = 5_000_000;

  // One command as it travels on s_axis.
  typedef struct {
    op_t                op;
    logic signed [11:0] sx;
    logic signed [11:0] sy;
    logic signed [11:0] ex;
    logic signed [11:0] ey;
    logic [10:0]        w;
    logic [10:0]        h;
    logic [15:0]        color;
  } cmd_t;

  typedef struct {
    logic [15:0] color;
    logic        valid;
  } reply_t;

  // Mirror of the framebuffer; turns each accepted command into the reply it must produce.
  class fb_mirror;
    logic [15:0] pix [FB_W*FB_H];
    reply_t      reply_q[$];
    int          mismatches;
    int          replies;
    int          hits;

    function new();
      foreach (pix[i]) pix[i] = '0;
      mismatches = 0;
      replies    = 0;
      hits       = 0;
    endfunction

    function void put_pixel(int x, int y, logic [15:0] color);
      if (x >= 0 && x < FB_W && y >= 0 && y < FB_H) pix[y*FB_W + x] = color;
    endfunction

    function void note_command(cmd_t c);
      int x, y, x1, y1, dx, dy, step_x, step_y, err, e2, xa, ya, xb, yb;
      reply_t r;
      r.color = '0;
      r.valid = 1'b0;
      case (c.op)
        OP_LINE: begin
          x  = int'(c.sx);
          y  = int'(c.sy);
          x1 = int'(c.ex);
          y1 = int'(c.ey);
          dx = (x1 > x) ? x1 - x : x - x1;
          dy = (y1 > y) ? y1 - y : y - y1;
          step_x = (x < x1) ? 1 : -1;
          step_y = (y < y1) ? 1 : -1;
          err = dx - dy;
          forever begin
            put_pixel(x, y, c.color);
            if (x == x1 && y == y1) break;
            e2 = 2 * err;
            if (e2 > -dy) begin
              err -= dy;
              x += step_x;
            end
            if (e2 < dx) begin
              err += dx;
              y += step_y;
            end
          end
        end
        OP_RECT: begin
          x  = int'(c.sx);
          y  = int'(c.sy);
          xa = (x < 0) ? 0 : x;
          ya = (y < 0) ? 0 : y;
          xb = x + int'(c.w);
          yb = y + int'(c.h);
          if (xb > FB_W) xb = FB_W;
          if (yb > FB_H) yb = FB_H;
          for (int i = ya; i < yb; i++)
            for (int j = xa; j < xb; j++)
              put_pixel(j, i, c.color);
        end
        OP_READ: begin
          x = int'(c.sx);
          y = int'(c.sy);
          if (x >= 0 && x < FB_W && y >= 0 && y < FB_H) begin
            r.color = pix[y*FB_W + x];
            r.valid = 1'b1;
          end
        end
        default: ;
      endcase
      reply_q.push_back(r);
    endfunction

    function void check_reply(logic [15:0] color, logic valid);
      reply_t r;
      replies++;
      if (reply_q.size() == 0) begin
        $error("result transfer with nothing pending: read_color %h read_valid %0b",
               color, valid);
        mismatches++;
        return;
      end
      r = reply_q.pop_front();
      if (r.valid) hits++;
      if (color !== r.color) begin
        $error("read_color mismatch: expected %h, actual %h", r.color, color);
        mismatches++;
      end
      if (valid !== r.valid) begin
        $error("read_valid mismatch: expected %0b, actual %0b", r.valid, valid);
        mismatches++;
      end
    endfunction

    function int pending();
      return reply_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic [S_TUSER_W-1:0] s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;

  fb_mirror sb = new();
  int       op_count[4];
  int       heavy_left = 24;   // budget of full-range commands, the longest-running ones
  bit       quiet = 1'b0;
  int       cycle_cnt = 0;

  framebuffer_line_rect_raster #(
    .FB_WIDTH (FB_W),
    .FB_HEIGHT(FB_H)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Abort on a hang; the cap is several times the slowest legal run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_CAP) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Check every result transfer against the oldest pending reply.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_reply(m_axis_tdata, m_axis_tuser);
  end

  // Receiver back-pressure: stall bursts between ready stretches.
  initial begin : ready_gen
    int n;
    m_axis_tready = 1'b1;
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          @(negedge clk);
          m_axis_tready = 1'b0;
        end
      end else begin
        n = $urandom_range(1, 24);
        repeat (n) begin
          @(negedge clk);
          m_axis_tready = 1'b1;
        end
      end
    end
  end

  function automatic cmd_t mk(op_t op, int sx, int sy, int ex, int ey, int w, int h, int color);
    cmd_t c;
    c.op    = op;
    c.sx    = 12'(sx);
    c.sy    = 12'(sy);
    c.ex    = 12'(ex);
    c.ey    = 12'(ey);
    c.w     = 11'(w);
    c.h     = 11'(h);
    c.color = 16'(color);
    return c;
  endfunction

  // Coordinate around the frame, a little outside each border.
  function automatic int near_coord();
    return int'($urandom_range(0, 159)) - 16;
  endfunction

  // Random command: unused fields keep full-range noise, used fields mostly stay near the frame.
  function automatic cmd_t random_cmd();
    cmd_t c;
    int   pick;
    c = mk(OP_NOP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      c.op = OP_LINE;
      if (heavy_left > 0 && $urandom_range(0, 39) == 0) begin
        heavy_left--;
      end else begin
        c.sx = 12'(near_coord());
        c.sy = 12'(near_coord());
        c.ex = 12'(near_coord());
        c.ey = 12'(near_coord());
      end
    end else if (pick < 55) begin
      c.op = OP_RECT;
      if (heavy_left > 0 && $urandom_range(0, 39) == 0) begin
        heavy_left--;
      end else begin
        c.sx = 12'(near_coord());
        c.sy = 12'(near_coord());
        c.w  = 11'($urandom_range(0, 20));
        c.h  = 11'($urandom_range(0, 20));
      end
    end else if (pick < 93) begin
      c.op = OP_READ;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        c.sx = 12'($urandom_range(0, FB_W-1));
        c.sy = 12'($urandom_range(0, FB_H-1));
      end else if (pick < 85) begin
        c.sx = 12'(int'($urandom_range(0, FB_W+5)) - 3);
        c.sy = 12'(int'($urandom_range(0, FB_H+5)) - 3);
      end
    end
    return c;
  endfunction

  // Present one command and hold it until the transfer completes.
  task automatic send_cmd(input cmd_t c);
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = c.op;
    s_axis_tdata  = {2'b00, c.color, c.h, c.w, c.ey, c.ex, c.sy, c.sx};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_command(c);
    op_count[c.op]++;
  endtask

  task automatic idle_for(input int n);
    repeat (n) begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
    end
  endtask

  initial begin : stim
    cmd_t dir_q[$];
    int   k;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_NOP;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: cleared frame, every border, clipping, degenerate shapes, no-op.
    dir_q.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0));
    dir_q.push_back(mk(OP_READ, FB_W-1, FB_H-1, 0, 0, 0, 0, 0));
    dir_q.push_back(mk(OP_RECT, 0, 0, 0, 0, FB_W, FB_H, 16'hFFFF));
    dir_q.push_back(mk(OP_READ, FB_W-1, 0, 0, 0, 0, 0, 0));
    dir_q.push_back(mk(OP_READ, -1, 5, 0, 0, 0, 0, 0));
    dir_q.push_back(mk(OP_READ, FB_W, 5, 0, 0, 0, 0, 0));
    dir_q.push_back(mk(OP_READ, 5, -1, 0, 0, 0, 0, 0));
    dir_q.push_back(mk(OP_READ, 5, FB_H, 0, 0, 0, 0, 0));
    dir_q.push_back(mk(OP_READ, -2048, -2048, 2047, 2047, 2047, 2047, 16'hFFFF));
    dir_q.push_back(mk(OP_READ, 2047, 2047, -2048, -2048, 0, 0, 0));
    dir_q.push_back(mk(OP_LINE, 10, 10, 10, 10, 0, 0, 16'h1234));
    dir_q.push_back(mk(OP_LINE, -2048, -2048, 2047, 2047, 0, 0, 16'h0000));
    dir_q.push_back(mk(OP_LINE, FB_W-1, 0, 0, FB_H-1, 0, 0, 16'hA5A5));
    dir_q.push_back(mk(OP_LINE, 100, 20, 3, 20, 0, 0, 16'h0F0F));
    dir_q.push_back(mk(OP_LINE, 5, 0, 9, 120, 0, 0, 16'hC3C3));
    dir_q.push_back(mk(OP_RECT, 0, 0, 0, 0, 0, 50, 16'h5555));
    dir_q.push_back(mk(OP_RECT, 0, 0, 0, 0, 40, 0, 16'h5555));
    dir_q.push_back(mk(OP_RECT, 100, 100, 0, 0, 2047, 2047, 16'h8001));
    dir_q.push_back(mk(OP_RECT, -2048, -2048, 0, 0, 2047, 2047, 16'h4242));
    dir_q.push_back(mk(OP_RECT, -5, -5, 0, 0, 10, 10, 16'h7FFF));
    dir_q.push_back(mk(OP_NOP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom));
    dir_q.push_back(mk(OP_READ, 10, 10, 0, 0, 0, 0, 0));
    dir_q.push_back(mk(OP_READ, 2, 2, 0, 0, 0, 0, 0));
    dir_q.push_back(mk(OP_READ, 64, 64, 0, 0, 0, 0, 0));
    dir_q.push_back(mk(OP_READ, 110, FB_H-1, 0, 0, 0, 0, 0));
    foreach (dir_q[i]) begin
      if ($urandom_range(0, 3) == 0) idle_for($urandom_range(1, 8));
      send_cmd(dir_q[i]);
    end

    // Random part; drop all idling for the last stretch.
    for (k = 0; k < RAND_CMDS; k++) begin
      if (k == RAND_CMDS - QUIET_CMDS) quiet = 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) idle_for($urandom_range(1, 8));
      send_cmd(random_cmd());
    end
    @(negedge clk);
    s_axis_tvalid = 1'b0;

    // Drain, then watch a while longer for stray results.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Sent %0d lines, %0d rectangles, %0d reads, %0d no-ops in %0d cycles.",
             op_count[OP_LINE], op_count[OP_RECT], op_count[OP_READ], op_count[OP_NOP],
             cycle_cnt);
    $display("Checked %0d results, %0d reads landed inside the frame, %0d mismatches.",
             sb.replies, sb.hits, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
